FILE: src/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Operation codes and shared types for the checked integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package cia_pkg;

  localparam int FUNC_W = 5;
  localparam int OUT_W  = 64;

  // Operation codes
  localparam logic [FUNC_W-1:0] F_ADD  = 5'd0;
  localparam logic [FUNC_W-1:0] F_SUB  = 5'd1;
  localparam logic [FUNC_W-1:0] F_MUL  = 5'd2;
  localparam logic [FUNC_W-1:0] F_SDIV = 5'd3;
  localparam logic [FUNC_W-1:0] F_UDIV = 5'd4;
  localparam logic [FUNC_W-1:0] F_SREM = 5'd5;
  localparam logic [FUNC_W-1:0] F_UREM = 5'd6;
  localparam logic [FUNC_W-1:0] F_AND  = 5'd7;
  localparam logic [FUNC_W-1:0] F_OR   = 5'd8;
  localparam logic [FUNC_W-1:0] F_XOR  = 5'd9;
  localparam logic [FUNC_W-1:0] F_SHL  = 5'd10;
  localparam logic [FUNC_W-1:0] F_LSHR = 5'd11;
  localparam logic [FUNC_W-1:0] F_ASHR = 5'd12;
  localparam logic [FUNC_W-1:0] F_EQ   = 5'd13;
  localparam logic [FUNC_W-1:0] F_NE   = 5'd14;
  localparam logic [FUNC_W-1:0] F_SLT  = 5'd15;
  localparam logic [FUNC_W-1:0] F_SLE  = 5'd16;
  localparam logic [FUNC_W-1:0] F_SGT  = 5'd17;
  localparam logic [FUNC_W-1:0] F_SGE  = 5'd18;
  localparam logic [FUNC_W-1:0] F_ULT  = 5'd19;
  localparam logic [FUNC_W-1:0] F_ULE  = 5'd20;
  localparam logic [FUNC_W-1:0] F_UGT  = 5'd21;
  localparam logic [FUNC_W-1:0] F_UGE  = 5'd22;

  // Control that travels down the cell chain with each word
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sa;   // operand signs
    logic              sb;
    logic              ok;   // early status (final for all but mul)
  } ctl_t;

endpackage

`default_nettype wire

FILE: src/checked_int64_alu.sv
// ----------------------------------------------------------------------------
// checked_int64_alu
// Overflow-checked integer ALU with a pipelined multiply/divide cell chain.
// ----------------------------------------------------------------------------
// Accepts one word per cycle unless back-pressure from the output has filled
// the chain, and returns one result word per input, in order. Every opcode
// passes through a decode stage, a chain of DATA_WIDTH cells that each settle
// one multiplier/dividend bit, and the output register. Each stage stalls
// only when it is full and the stage after it is stalled, so bubbles in the
// chain are filled while a result waits at the output.
`default_nettype none

module checked_int64_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [cia_pkg::FUNC_W-1:0] func,
  input  wire logic [cia_pkg::OUT_W-1:0]  lhs,
  input  wire logic [cia_pkg::OUT_W-1:0]  rhs,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [cia_pkg::OUT_W-1:0]  result,
  output      logic                      ok
);

  localparam int W = DATA_WIDTH;

  logic           cv   [0:W];
  logic           cr   [0:W];
  cia_pkg::ctl_t  cc   [0:W];
  logic [W-1:0]   cp   [0:W];
  logic [W-1:0]   cx   [0:W];
  logic [W-1:0]   cy   [0:W];
  logic [2*W-1:0] cacc [0:W];
  logic [W-1:0]   crem [0:W];

  cia_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .lhs       (lhs),
    .rhs       (rhs),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_ctl   (cc[0]),
    .out_pres  (cp[0]),
    .out_x     (cx[0]),
    .out_y     (cy[0])
  );

  assign cacc[0] = '0;
  assign crem[0] = '0;

  // Cell chain
  for (genvar i = 0; i < W; i++) begin : g_cell
    cia_cell #(.W(W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_ctl    (cc[i]),
      .in_pres   (cp[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_acc    (cacc[i]),
      .in_rem    (crem[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_ctl   (cc[i+1]),
      .out_pres  (cp[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_acc   (cacc[i+1]),
      .out_rem   (crem[i+1])
    );
  end

  cia_back #(.W(W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[W]),
    .in_ready  (cr[W]),
    .in_ctl    (cc[W]),
    .in_pres   (cp[W]),
    .in_x      (cx[W]),
    .in_acc    (cacc[W]),
    .in_rem    (crem[W]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .ok        (ok)
  );

  // A failed operation always reports a zero result
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> result == '0)
    else $error("failed result not zero");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A ready sink lets the whole chain move, so input is never blocked
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with sink ready");

endmodule

`default_nettype wire

FILE: src/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front
// Decode stage: results of the operations that need no cell chain, fault checks and the operands
// for the multiply/divide cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cia_front #(
  parameter int W = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [cia_pkg::FUNC_W-1:0] func,
  input  wire logic [cia_pkg::OUT_W-1:0]  lhs,
  input  wire logic [cia_pkg::OUT_W-1:0]  rhs,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      cia_pkg::ctl_t             out_ctl,
  output      logic [W-1:0]              out_pres,
  output      logic [W-1:0]              out_x,
  output      logic [W-1:0]              out_y
);

  localparam int           NB    = $clog2(W);
  localparam logic [W-1:0] W_VAL = W'(W);
  localparam logic [W-1:0] MINV  = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]  a, b, ma, mb, sum, dif, shl_r;
  logic          sa, sb, amt_ok, bnz;
  logic [NB-1:0] n;
  cia_pkg::ctl_t ctl_c;
  logic [W-1:0]  pres_c, x_c, y_c;

  // Operand views and magnitudes
  assign a      = lhs[W-1:0];
  assign b      = rhs[W-1:0];
  assign sa     = a[W-1];
  assign sb     = b[W-1];
  assign ma     = sa ? (~a + 1'b1) : a;
  assign mb     = sb ? (~b + 1'b1) : b;
  assign sum    = a + b;
  assign dif    = a - b;
  assign bnz    = (b != '0);
  assign amt_ok = !sb && (b < W_VAL);
  assign n      = b[NB-1:0];
  assign shl_r  = a << n;

  // Per-opcode early result and status
  always_comb begin
    ctl_c.func = func;
    ctl_c.sa   = sa;
    ctl_c.sb   = sb;
    ctl_c.ok   = 1'b1;
    pres_c     = '0;
    x_c        = ma;
    y_c        = mb;
    unique case (func) inside
      cia_pkg::F_ADD: begin
        pres_c   = sum;
        ctl_c.ok = !((a[W-1] ^ sum[W-1]) & (b[W-1] ^ sum[W-1]));
      end
      cia_pkg::F_SUB: begin
        pres_c   = dif;
        ctl_c.ok = !((a[W-1] ^ b[W-1]) & (a[W-1] ^ dif[W-1]));
      end
      cia_pkg::F_MUL: ctl_c.ok = 1'b1;
      cia_pkg::F_SDIV, cia_pkg::F_SREM: begin
        ctl_c.ok = bnz && !(a == MINV && b == '1);
      end
      cia_pkg::F_UDIV, cia_pkg::F_UREM: begin
        x_c      = a;
        y_c      = b;
        ctl_c.ok = bnz;
      end
      cia_pkg::F_AND: pres_c = a & b;
      cia_pkg::F_OR:  pres_c = a | b;
      cia_pkg::F_XOR: pres_c = a ^ b;
      cia_pkg::F_SHL: begin
        pres_c   = shl_r;
        ctl_c.ok = amt_ok && (shl_r[W-1] == a[W-1]);
      end
      cia_pkg::F_LSHR: begin
        pres_c   = a >> n;
        ctl_c.ok = amt_ok;
      end
      cia_pkg::F_ASHR: begin
        pres_c   = W'($signed(a) >>> n);
        ctl_c.ok = amt_ok;
      end
      cia_pkg::F_EQ:  pres_c = W'(a == b);
      cia_pkg::F_NE:  pres_c = W'(a != b);
      cia_pkg::F_SLT: pres_c = W'($signed(a) <  $signed(b));
      cia_pkg::F_SLE: pres_c = W'($signed(a) <= $signed(b));
      cia_pkg::F_SGT: pres_c = W'($signed(a) >  $signed(b));
      cia_pkg::F_SGE: pres_c = W'($signed(a) >= $signed(b));
      cia_pkg::F_ULT: pres_c = W'(a <  b);
      cia_pkg::F_ULE: pres_c = W'(a <= b);
      cia_pkg::F_UGT: pres_c = W'(a >  b);
      cia_pkg::F_UGE: pres_c = W'(a >= b);
      default:        ctl_c.ok = 1'b0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_ctl  <= ctl_c;
      out_pres <= pres_c;
      out_x    <= x_c;
      out_y    <= y_c;
    end
  end

endmodule

`default_nettype wire

FILE: src/cia_cell.sv
// ----------------------------------------------------------------------------
// cia_cell
// One step of the chain: a shift-add multiply step and a restoring divide
// step on the next operand bit, then a register to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cia_cell #(
  parameter int W = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire cia_pkg::ctl_t  in_ctl,
  input  wire logic [W-1:0]   in_pres,
  input  wire logic [W-1:0]   in_x,
  input  wire logic [W-1:0]   in_y,
  input  wire logic [2*W-1:0] in_acc,
  input  wire logic [W-1:0]   in_rem,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      cia_pkg::ctl_t  out_ctl,
  output      logic [W-1:0]   out_pres,
  output      logic [W-1:0]   out_x,
  output      logic [W-1:0]   out_y,
  output      logic [2*W-1:0] out_acc,
  output      logic [W-1:0]   out_rem
);

  logic           xm, ge;
  logic [W:0]     part, diff;
  logic [W-1:0]   rem_next, x_next;
  logic [2*W-1:0] acc_next;

  // Multiply: MSB-first shift and add
  assign xm       = in_x[W-1];
  assign acc_next = {in_acc[2*W-2:0], 1'b0} + (xm ? {{W{1'b0}}, in_y} : '0);

  // Divide: trial subtract, quotient bit enters x from the bottom
  assign part     = {in_rem, xm};
  assign diff     = part - {1'b0, in_y};
  assign ge       = (part >= {1'b0, in_y});
  assign rem_next = ge ? diff[W-1:0] : part[W-1:0];
  assign x_next   = {in_x[W-2:0], ge};

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_ctl  <= in_ctl;
      out_pres <= in_pres;
      out_x    <= x_next;
      out_y    <= in_y;
      out_acc  <= acc_next;
      out_rem  <= rem_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/cia_back.sv
// ----------------------------------------------------------------------------
// cia_back
// Result stage: sign fix-up and overflow check for multiply/divide, then
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cia_back #(
  parameter int W = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire cia_pkg::ctl_t            in_ctl,
  input  wire logic [W-1:0]             in_pres,
  input  wire logic [W-1:0]             in_x,
  input  wire logic [2*W-1:0]           in_acc,
  input  wire logic [W-1:0]             in_rem,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [cia_pkg::OUT_W-1:0] result,
  output      logic                     ok
);

  logic         neg, mok, ok_c;
  logic [W-1:0] plo, r_c;

  // Product check: fits in W signed bits, MIN allowed only when negative
  assign plo = in_acc[W-1:0];
  assign neg = (in_ctl.sa ^ in_ctl.sb) && (in_acc != '0);
  assign mok = (in_acc[2*W-1:W] == '0) &&
               (!plo[W-1] || (neg && plo[W-2:0] == '0));

  always_comb begin
    r_c  = in_pres;
    ok_c = in_ctl.ok;
    unique case (in_ctl.func)
      cia_pkg::F_MUL: begin
        r_c  = neg ? (~plo + 1'b1) : plo;
        ok_c = mok;
      end
      cia_pkg::F_SDIV: r_c = (in_ctl.sa ^ in_ctl.sb) ? (~in_x + 1'b1) : in_x;
      cia_pkg::F_SREM: r_c = in_ctl.sa ? (~in_rem + 1'b1) : in_rem;
      cia_pkg::F_UDIV: r_c = in_x;
      cia_pkg::F_UREM: r_c = in_rem;
      default:         r_c = in_pres;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      result <= ok_c ? cia_pkg::OUT_W'($signed(r_c)) : '0;
      ok     <= ok_c;
    end
  end

endmodule

`default_nettype wire
